FILE: rtl/sjet_pkg.sv
`timescale 1ns / 1ps

package sjet_pkg;

	// direction register codes
	localparam logic DIR_SJIS_TO_EUC = 1'b0;
	localparam logic DIR_EUC_TO_SJIS = 1'b1;

	localparam logic [7:0] SPACE_BYTE = 8'h20;
	localparam logic [7:0] HIGH_BIT   = 8'h80;

	// bytes produced by one input transaction
	typedef struct packed {
		logic       present;
		logic       two;
		logic [7:0] byte0;
		logic [7:0] byte1;
	} res_t;

	// shift-jis lead byte ranges
	function automatic logic is_sjis_lead(input logic [7:0] c);
		return (c >= 8'h81 && c <= 8'h9f) || c >= 8'he0;
	endfunction

	// shift-jis pair to jis pair, 8-bit wrapping
	function automatic logic [15:0] sjis_to_jis(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] h;
		logic [7:0] l;
		h = (hi <= 8'h9f) ? hi - 8'h70 : hi - 8'hb0;
		h = {h[6:0], 1'b0};
		if (lo >= 8'h9f) begin
			l = lo - 8'h7e;
		end else begin
			h = h - 8'h01;
			l = (lo >= 8'h80) ? lo - 8'h20 : lo - 8'h1f;
		end
		return {h, l};
	endfunction

	// jis pair (7-bit bytes) to shift-jis pair, 8-bit wrapping
	function automatic logic [15:0] jis_to_sjis(input logic [7:0] hi, input logic [7:0] lo);
		logic [7:0] h;
		logic [7:0] l;
		logic [7:0] d;
		l = hi[0] ? lo + 8'h1f : lo + 8'h7d;
		if (l >= 8'h7f) begin
			l = l + 8'h01;
		end
		if (hi >= 8'h5f) begin
			d = hi - 8'h5f;
			h = {1'b0, d[7:1]} + 8'he0;
		end else begin
			d = hi - 8'h21;
			h = {1'b0, d[7:1]} + 8'h81;
		end
		return {h, l};
	endfunction

	// output bytes for one byte given the held state seen at its acceptance
	function automatic res_t convert(input logic dir, input logic hv, input logic [7:0] hb,
			input logic [7:0] b, input logic fin);
		res_t r;
		logic [15:0] p;
		r = '{present: 1'b1, two: 1'b0, byte0: b, byte1: b};
		if (dir == DIR_SJIS_TO_EUC) begin
			p = sjis_to_jis(hb, b);
			if (hv) begin
				r.two   = 1'b1;
				r.byte0 = p[15:8] | HIGH_BIT;
				r.byte1 = p[7:0] | HIGH_BIT;
			end else if (is_sjis_lead(b)) begin
				r.present = fin;
				r.byte0   = SPACE_BYTE;
			end
		end else begin
			p = jis_to_sjis(hb & 8'h7f, b & 8'h7f);
			if (hv) begin
				r.two = 1'b1;
				if (b[7]) begin
					r.byte0 = p[15:8];
					r.byte1 = p[7:0];
				end else begin
					r.byte0 = hb;
					r.byte1 = b;
				end
			end else if (b[7] && !fin) begin
				r.present = 1'b0;
			end
		end
		return r;
	endfunction

endpackage

FILE: rtl/sjet_in_if.sv
`timescale 1ns / 1ps

interface sjet_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       in_end;

	modport source (output valid, output in_byte, output in_end, input ready);
	modport sink (input valid, input in_byte, input in_end, output ready);
endinterface

FILE: rtl/sjet_out_if.sv
`timescale 1ns / 1ps

interface sjet_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_byte;
	logic       run_last;
	logic       string_end;

	modport source (output valid, output out_byte, output run_last, output string_end,
		input ready);
	modport sink (input valid, input out_byte, input run_last, input string_end,
		output ready);
endinterface

FILE: rtl/sjis_euc_transcoder.sv
`timescale 1ns / 1ps

// channel    dir   payload                          handshake
// in_ch      in    in_byte[7:0], in_end             valid/ready
// out_ch     out   out_byte[7:0], run_last, string_end  valid/ready
// cfg        in    cfg_wdata (direction)            cfg_we, no wait
//
// one input transaction per cycle unless the output holds it back; its first output byte is offered
// after the input stage, from the result register; a converted pair leaves byte0 then byte1,
// and the result register holds it until byte1 is taken, so the output port sets the byte rate
// arst_n clears the held lead byte, the pipeline valids and direction
// a stalled output holds its byte and backs up through the input stage to in_ch.ready
module sjis_euc_transcoder (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_wdata,
	sjet_in_if.sink            in_ch,
	sjet_out_if.source         out_ch
);

	logic       direction_q;
	logic       held_valid_q;
	logic [7:0] held_byte_q;

	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       end_s1;
	logic       hv_s1;
	logic [7:0] hb_s1;

	logic       valid_s2;
	logic       two_s2;
	logic       end_s2;
	logic [7:0] byte0_s2;
	logic [7:0] byte1_s2;
	logic       sel_q;

	logic       in_fire;
	logic       out_fire;
	logic       last_out;
	logic       s2_free;
	logic       advance;
	logic       next_hold;
	sjet_pkg::res_t res;

	// handshakes
	assign last_out = !two_s2 || sel_q;
	assign out_fire = valid_s2 && out_ch.ready;
	assign s2_free  = !valid_s2 || (out_fire && last_out);
	assign advance  = valid_s1 && s2_free;
	assign in_ch.ready = !valid_s1 || s2_free;
	assign in_fire  = in_ch.valid && in_ch.ready;

	// whether the accepted byte waits for its partner
	always_comb begin
		if (direction_q == sjet_pkg::DIR_SJIS_TO_EUC) begin
			next_hold = !held_valid_q && sjet_pkg::is_sjis_lead(in_ch.in_byte) && !in_ch.in_end;
		end else begin
			next_hold = !held_valid_q && in_ch.in_byte[7] && !in_ch.in_end;
		end
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			direction_q <= sjet_pkg::DIR_SJIS_TO_EUC;
		end else if (cfg_we) begin
			direction_q <= cfg_wdata;
		end
	end

	// held byte state, updated as each transaction is accepted
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_byte_q  <= 8'h00;
		end else if (in_fire) begin
			held_valid_q <= next_hold;
			held_byte_q  <= next_hold ? in_ch.in_byte : 8'h00;
		end
	end

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_fire) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			byte_s1 <= in_ch.in_byte;
			end_s1  <= in_ch.in_end;
			hv_s1   <= held_valid_q;
			hb_s1   <= held_byte_q;
		end
	end

	// conversion
	assign res = sjet_pkg::convert(direction_q, hv_s1, hb_s1, byte_s1, end_s1);

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			sel_q    <= 1'b0;
		end else if (advance) begin
			valid_s2 <= res.present;
			sel_q    <= 1'b0;
		end else if (out_fire) begin
			if (last_out) begin
				valid_s2 <= 1'b0;
				sel_q    <= 1'b0;
			end else begin
				sel_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			two_s2   <= res.two;
			end_s2   <= end_s1;
			byte0_s2 <= res.byte0;
			byte1_s2 <= res.byte1;
		end
	end

	// output port
	assign out_ch.valid      = valid_s2;
	assign out_ch.out_byte   = sel_q ? byte1_s2 : byte0_s2;
	assign out_ch.run_last   = last_out;
	assign out_ch.string_end = last_out && end_s2;

endmodule
